/* src/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

/* src/thcc_pkg.sv */
// Package with widths, constants, tables and helper functions of the compass heading core.
package thcc_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ANGLE_BITS = 16;

	localparam int AW = ANGLE_BITS + 4;
	localparam int CW = 32;
	localparam int CS_W = 17;
	localparam int VVW = 19;
	localparam int RW = 19;
	localparam int HW = 22;
	localparam int VW = HW + 22;
	localparam int SC_LAT = CORDIC_STAGES + 2;
	localparam int DEPTH = 2 * SC_LAT + CORDIC_STAGES + 7;

	localparam int IN_W = 80;
	localparam int OUT_W = 88;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MOUNT = 4'h0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_X = 4'h1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y = 4'h2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z = 4'h3;

	localparam logic [15:0] GAIN_RESET = 16'd16384;

	localparam logic signed [CW-1:0] K_Q30 = 32'sd652032874;
	localparam logic signed [CW-1:0] CS_RND = 32'sd32768;
	localparam longint PI_Q32 = 64'sd13493037705;

	localparam longint PI_L = (PI_Q32 + (64'sd1 <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
	localparam longint HALF_L = (PI_Q32 + (64'sd1 <<< (32 - ANGLE_BITS))) >>> (33 - ANGLE_BITS);
	localparam logic signed [AW-1:0] PI_U = PI_L[AW-1:0];
	localparam logic signed [AW-1:0] HALF_U = HALF_L[AW-1:0];

	// Arctangent of 2^-i in Q32.
	localparam longint ATAN_Q32 [0:23] = '{
		64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
		64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
		64'sd16777131, 64'sd8388597, 64'sd4194303, 64'sd2097152,
		64'sd1048576, 64'sd524288, 64'sd262144, 64'sd131072,
		64'sd65536, 64'sd32768, 64'sd16384, 64'sd8192,
		64'sd4096, 64'sd2048, 64'sd1024, 64'sd512
	};

	localparam logic signed [15:0] M_P1 = 16'sd16384;
	localparam logic signed [15:0] M_N1 = -16'sd16384;
	localparam logic signed [15:0] M_PR = 16'sd11585;
	localparam logic signed [15:0] M_NR = -16'sd11585;
	localparam logic signed [15:0] M_Z0 = 16'sd0;

	// Sixteen mounting matrices, row major, Q1.14.
	localparam logic signed [15:0] MOUNT_MAT [0:15][0:8] = '{
		'{M_P1, M_Z0, M_Z0, M_Z0, M_P1, M_Z0, M_Z0, M_Z0, M_P1},
		'{M_PR, M_PR, M_Z0, M_NR, M_PR, M_Z0, M_Z0, M_Z0, M_P1},
		'{M_Z0, M_P1, M_Z0, M_N1, M_Z0, M_Z0, M_Z0, M_Z0, M_P1},
		'{M_NR, M_PR, M_Z0, M_NR, M_NR, M_Z0, M_Z0, M_Z0, M_P1},
		'{M_N1, M_Z0, M_Z0, M_Z0, M_N1, M_Z0, M_Z0, M_Z0, M_P1},
		'{M_NR, M_NR, M_Z0, M_PR, M_NR, M_Z0, M_Z0, M_Z0, M_P1},
		'{M_Z0, M_N1, M_Z0, M_P1, M_Z0, M_Z0, M_Z0, M_Z0, M_P1},
		'{M_PR, M_NR, M_Z0, M_PR, M_PR, M_Z0, M_Z0, M_Z0, M_P1},
		'{M_P1, M_Z0, M_Z0, M_Z0, M_N1, M_Z0, M_Z0, M_Z0, M_N1},
		'{M_PR, M_NR, M_Z0, M_NR, M_NR, M_Z0, M_Z0, M_Z0, M_N1},
		'{M_Z0, M_N1, M_Z0, M_N1, M_Z0, M_Z0, M_Z0, M_Z0, M_N1},
		'{M_NR, M_NR, M_Z0, M_NR, M_PR, M_Z0, M_Z0, M_Z0, M_N1},
		'{M_N1, M_Z0, M_Z0, M_Z0, M_P1, M_Z0, M_Z0, M_Z0, M_N1},
		'{M_NR, M_PR, M_Z0, M_PR, M_PR, M_Z0, M_Z0, M_Z0, M_N1},
		'{M_Z0, M_P1, M_Z0, M_P1, M_Z0, M_Z0, M_Z0, M_Z0, M_N1},
		'{M_PR, M_PR, M_Z0, M_PR, M_NR, M_Z0, M_Z0, M_Z0, M_N1}
	};

	localparam logic signed [HW-1:0] LVL_MAX = 22'sd524287;
	localparam logic signed [HW-1:0] LVL_MIN = -22'sd524288;
	localparam logic signed [CS_W-1:0] Q14_MAX = 17'sd16384;
	localparam logic signed [CS_W-1:0] Q14_MIN = -17'sd16384;
	localparam logic signed [16:0] HD_MAX = 17'sd25736;
	localparam logic signed [16:0] HD_MIN = -17'sd25736;

	typedef struct packed {
		logic signed [15:0] hd;
		logic signed [19:0] hxs;
		logic signed [19:0] hys;
	} side_t;

	function automatic logic signed [AW-1:0] atan_u(input int i);
		longint t;
		logic signed [63:0] w;
		t = (i < 24) ? (ATAN_Q32[i] + (64'sd1 <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS) : 0;
		w = t;
		return w[AW-1:0];
	endfunction

	function automatic logic signed [AW-1:0] angle_in(input logic signed [15:0] a);
		logic signed [ANGLE_BITS+16:0] t;
		t = {a[15], a, {ANGLE_BITS{1'b0}}};
		t = t + (ANGLE_BITS + 17)'(4096);
		return t[AW+12:13];
	endfunction

	function automatic logic signed [19:0] sat_level(input logic signed [HW-1:0] v);
		logic signed [HW-1:0] c;
		c = v;
		if (v > LVL_MAX) c = LVL_MAX;
		else if (v < LVL_MIN) c = LVL_MIN;
		return c[19:0];
	endfunction

	function automatic logic signed [15:0] sat_q14(input logic signed [CS_W-1:0] v);
		logic signed [CS_W-1:0] c;
		c = v;
		if (v > Q14_MAX) c = Q14_MAX;
		else if (v < Q14_MIN) c = Q14_MIN;
		return c[15:0];
	endfunction

endpackage

/* src/tilt_compensated_compass_heading_core.sv */
// Top level of the tilt compensated compass heading core.
//
// The input stream carries one magnetometer sample with roll and pitch per item;
// the output stream carries heading, its cosine and sine, and the level X and Y
// field components. A separate write channel sets the mounting matrix select and
// the three axis gains; it is always ready and should be written while idle.
// Every stage is a register stage, so while s_tready is high one item is accepted
// in every cycle and the throughput is one item per clock. The roll and pitch
// sine/cosine CORDICs run in parallel, followed in series by the vectoring CORDIC
// and the heading sine/cosine CORDIC. Reset clears all valid bits and loads the
// configuration registers with their reset values. When the receiver stalls, a
// result waits in the output register and the next one lands in a skid register;
// only once both are full does the whole pipeline freeze and s_tready drop, and
// nothing is lost or repeated.
module tilt_compensated_compass_heading_core import thcc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// raw_x, raw_y, raw_z, roll_angle, pitch_angle
	input logic [IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// heading, heading_cos, heading_sin, level_x, level_y
	output logic [OUT_W-1:0] m_tdata
);

	localparam int N = CORDIC_STAGES;

	logic [3:0] mount_q;
	logic [15:0] gain_x_q;
	logic [15:0] gain_y_q;
	logic [15:0] gain_z_q;

	logic en;
	logic vld_q [0:DEPTH-1];

	logic signed [16:0] nx, ny, nz, gx, gy, gz;
	logic signed [33:0] px_s1, py_s1, pz_s1;
	logic signed [AW-1:0] roll_s1, pitch_s1;

	logic signed [33:0] tx, ty, tz;
	logic signed [VVW-1:0] v_s2 [0:2];

	logic signed [36:0] mac [0:2];
	logic signed [RW-1:0] r_c [0:2];
	logic signed [RW-1:0] r_s3 [0:2];
	logic signed [RW-1:0] rd_q [0:N-1][0:2];

	logic signed [CS_W-1:0] cr, sr, cp, sp;

	logic signed [33:0] srsp_s4, crsp_s4;
	logic signed [35:0] r0cp_s4, r1cr_s4, r2sr_s4;
	logic signed [RW-1:0] r1_s4, r2_s4;

	logic signed [52:0] p1_s5, p2_s5;
	logic signed [35:0] r0cp_s5;
	logic signed [36:0] hyt;
	logic signed [HW-1:0] hy_s5;

	logic signed [55:0] hxt;
	logic signed [HW-1:0] hx_s6, hy_s6;

	logic signed [VW-1:0] xe, ye, x0, y0;
	logic signed [AW-1:0] z0;
	logic signed [VW-1:0] vx_q [0:N];
	logic signed [VW-1:0] vy_q [0:N];
	logic signed [AW-1:0] vz_q [0:N];
	logic vzero_q [0:N];
	logic signed [19:0] vhx_q [0:N];
	logic signed [19:0] vhy_q [0:N];

	logic signed [AW-1:0] ang_s9;
	logic signed [19:0] hxs_s9, hys_s9;
	logic signed [AW+13:0] ht;
	logic signed [16:0] hd17;
	logic signed [16:0] hd_sat;
	side_t side_c;
	side_t dl_q [0:SC_LAT-1];

	logic signed [CS_W-1:0] hc, hs;
	logic [OUT_W-1:0] res_s10;

	logic out_valid_q, skid_valid_q;
	logic [OUT_W-1:0] out_data_q, skid_data_q;
	logic push, pop;
	logic out_valid_d, skid_valid_d, out_ld_new, out_ld_skid, skid_ld;

	assign cfg_ready = 1'b1;
	assign en = !skid_valid_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_q <= '0;
			gain_x_q <= GAIN_RESET;
			gain_y_q <= GAIN_RESET;
			gain_z_q <= GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MOUNT: mount_q <= cfg_data[3:0];
				REG_GAIN_X: gain_x_q <= cfg_data;
				REG_GAIN_Y: gain_y_q <= cfg_data;
				REG_GAIN_Z: gain_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DEPTH; j++) vld_q[j] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int j = 1; j < DEPTH; j++) vld_q[j] <= vld_q[j-1];
		end
	end

	// X and Z are negated before scaling.
	always_comb begin
		nx = -{s_tdata[15], s_tdata[15:0]};
		ny = {s_tdata[31], s_tdata[31:16]};
		nz = -{s_tdata[47], s_tdata[47:32]};
		gx = {1'b0, gain_x_q};
		gy = {1'b0, gain_y_q};
		gz = {1'b0, gain_z_q};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= nx * gx;
			py_s1 <= ny * gy;
			pz_s1 <= nz * gz;
			roll_s1 <= angle_in(s_tdata[63:48]);
			pitch_s1 <= angle_in(s_tdata[79:64]);
		end
	end

	always_comb begin
		tx = px_s1 + 34'sd8192;
		ty = py_s1 + 34'sd8192;
		tz = pz_s1 + 34'sd8192;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s2[0] <= tx[VVW+13:14];
			v_s2[1] <= ty[VVW+13:14];
			v_s2[2] <= tz[VVW+13:14];
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mac[k] = MOUNT_MAT[mount_q][3*k] * v_s2[0] + MOUNT_MAT[mount_q][3*k+1] * v_s2[1]
				+ MOUNT_MAT[mount_q][3*k+2] * v_s2[2] + 37'sd8192;
			r_c[k] = mac[k][RW+13:14];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3 <= r_c;
			rd_q[0] <= r_s3;
			for (int j = 1; j < N; j++) rd_q[j] <= rd_q[j-1];
		end
	end

	thcc_sincos u_roll (
		.clk(clk),
		.en(en),
		.angle(roll_s1),
		.cos_val(cr),
		.sin_val(sr)
	);

	thcc_sincos u_pitch (
		.clk(clk),
		.en(en),
		.angle(pitch_s1),
		.cos_val(cp),
		.sin_val(sp)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			srsp_s4 <= sr * sp;
			crsp_s4 <= cr * sp;
			r0cp_s4 <= rd_q[N-1][0] * cp;
			r1cr_s4 <= rd_q[N-1][1] * cr;
			r2sr_s4 <= rd_q[N-1][2] * sr;
			r1_s4 <= rd_q[N-1][1];
			r2_s4 <= rd_q[N-1][2];
		end
	end

	assign hyt = r1cr_s4 - r2sr_s4 + 37'sd8192;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s5 <= r1_s4 * srsp_s4;
			p2_s5 <= r2_s4 * crsp_s4;
			r0cp_s5 <= r0cp_s4;
			hy_s5 <= hyt[HW+13:14];
		end
	end

	assign hxt = (56'(r0cp_s5) <<< 14) + 56'(p1_s5) + 56'(p2_s5) + (56'sd1 <<< 27);

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s6 <= hxt[HW+27:28];
			hy_s6 <= hy_s5;
		end
	end

	// The heading is atan2(-Hy, Hx); a vector in the left half plane is flipped.
	always_comb begin
		xe = VW'(hx_s6) <<< 20;
		ye = -(VW'(hy_s6) <<< 20);
		x0 = xe;
		y0 = ye;
		z0 = '0;
		if (hx_s6 < 0) begin
			x0 = -xe;
			y0 = -ye;
			z0 = (ye >= 0) ? PI_U : -PI_U;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_q[0] <= x0;
			vy_q[0] <= y0;
			vz_q[0] <= z0;
			vzero_q[0] <= (hx_s6 == '0) && (hy_s6 == '0);
			vhx_q[0] <= sat_level(hx_s6);
			vhy_q[0] <= sat_level(hy_s6);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam logic signed [AW-1:0] ATAN_I = atan_u(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (vy_q[i][VW-1]) begin
					vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
					vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
					vz_q[i+1] <= vz_q[i] - ATAN_I;
				end else begin
					vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
					vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
					vz_q[i+1] <= vz_q[i] + ATAN_I;
				end
				vzero_q[i+1] <= vzero_q[i];
				vhx_q[i+1] <= vhx_q[i];
				vhy_q[i+1] <= vhy_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s9 <= vzero_q[N] ? '0 : vz_q[N];
			hxs_s9 <= vhx_q[N];
			hys_s9 <= vhy_q[N];
		end
	end

	always_comb begin
		ht = $signed({ang_s9[AW-1], ang_s9, 13'b0}) + ((AW + 14)'(1) <<< (ANGLE_BITS - 1));
		hd17 = ht[ANGLE_BITS+16:ANGLE_BITS];
		hd_sat = hd17;
		if (hd17 > HD_MAX) hd_sat = HD_MAX;
		else if (hd17 < HD_MIN) hd_sat = HD_MIN;
		side_c.hd = hd_sat[15:0];
		side_c.hxs = hxs_s9;
		side_c.hys = hys_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dl_q[0] <= side_c;
			for (int j = 1; j < SC_LAT; j++) dl_q[j] <= dl_q[j-1];
		end
	end

	thcc_sincos u_head (
		.clk(clk),
		.en(en),
		.angle(ang_s9),
		.cos_val(hc),
		.sin_val(hs)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s10 <= {dl_q[SC_LAT-1].hys, dl_q[SC_LAT-1].hxs, sat_q14(hs), sat_q14(hc),
				dl_q[SC_LAT-1].hd};
		end
	end

	assign push = en && vld_q[DEPTH-1];
	assign pop = out_valid_q && m_tready;

	always_comb begin
		out_valid_d = out_valid_q;
		skid_valid_d = skid_valid_q;
		out_ld_new = 1'b0;
		out_ld_skid = 1'b0;
		skid_ld = 1'b0;
		if (skid_valid_q) begin
			if (pop) begin
				out_ld_skid = 1'b1;
				skid_valid_d = 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_ld_new = 1'b1;
				out_valid_d = 1'b1;
			end else begin
				skid_ld = 1'b1;
				skid_valid_d = 1'b1;
			end
		end else if (pop) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_valid_d;
			skid_valid_q <= skid_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld_new) out_data_q <= res_s10;
		else if (out_ld_skid) out_data_q <= skid_data_q;
		if (skid_ld) skid_data_q <= res_s10;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

/* src/thcc_sincos.sv */
// Pipelined rotation CORDIC giving the Q1.14 cosine and sine of an internal angle.
module thcc_sincos import thcc_pkg::*; (
	input logic clk,
	input logic en,
	input logic signed [AW-1:0] angle,
	output logic signed [CS_W-1:0] cos_val,
	output logic signed [CS_W-1:0] sin_val
);

	logic signed [CW-1:0] x_q [0:CORDIC_STAGES];
	logic signed [CW-1:0] y_q [0:CORDIC_STAGES];
	logic signed [AW-1:0] z_q [0:CORDIC_STAGES];
	logic neg_q [0:CORDIC_STAGES];
	logic signed [AW-1:0] z_fold;
	logic fold;
	logic signed [CW-1:0] xr;
	logic signed [CW-1:0] yr;
	logic signed [CS_W-1:0] c_c;
	logic signed [CS_W-1:0] s_c;
	logic signed [CS_W-1:0] c_q;
	logic signed [CS_W-1:0] s_q;

	always_comb begin
		fold = 1'b1;
		z_fold = angle;
		if (angle > HALF_U) begin
			z_fold = angle - PI_U;
		end else if (angle < -HALF_U) begin
			z_fold = angle + PI_U;
		end else begin
			fold = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= K_Q30;
			y_q[0] <= '0;
			z_q[0] <= z_fold;
			neg_q[0] <= fold;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		localparam logic signed [AW-1:0] ATAN_I = atan_u(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[i][AW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - ATAN_I;
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + ATAN_I;
				end
				neg_q[i+1] <= neg_q[i];
			end
		end
	end

	always_comb begin
		xr = x_q[CORDIC_STAGES] + CS_RND;
		yr = y_q[CORDIC_STAGES] + CS_RND;
		c_c = CS_W'($signed(xr[CW-1:16]));
		s_c = CS_W'($signed(yr[CW-1:16]));
		if (neg_q[CORDIC_STAGES]) begin
			c_c = -c_c;
			s_c = -s_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_q <= c_c;
			s_q <= s_c;
		end
	end

	assign cos_val = c_q;
	assign sin_val = s_q;

endmodule

/* src/thcc_checker.sv */
// Port level checker of the compass heading core and its bind statement.
`include "assert_macros.svh"

module thcc_checker import thcc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	logic signed [15:0] hd_w;
	logic signed [15:0] hc_w;

	assign hd_w = m_tdata[15:0];
	assign hc_w = m_tdata[31:16];

	`ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output held")
	`ASSERT_NEVER(a_stall_empty, !s_tready && !m_tvalid, "input stalled with no output item")
	`ASSERT_CLK(a_cos_range, m_tvalid |-> (hc_w <= 16'sd16384) && (hc_w >= -16'sd16384), "cos")
	`ASSERT_CLK(a_head_range, m_tvalid |-> (hd_w <= 16'sd25736) && (hd_w >= -16'sd25736), "head")

endmodule

bind tilt_compensated_compass_heading_core thcc_checker u_thcc_checker (.*);

/* tb/tilt_compensated_compass_heading_core_tb.sv */
// Self-checking testbench of the tilt compensated compass heading core.
module tilt_compensated_compass_heading_core_tb;
	import thcc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic signed [15:0] heading;
		logic signed [15:0] hcos;
		logic signed [15:0] hsin;
		logic signed [19:0] lvl_x;
		logic signed [19:0] lvl_y;
	} heading_t;

	typedef struct packed {
		logic [15:0] rx;
		logic [15:0] ry;
		logic [15:0] rz;
		logic [15:0] roll;
		logic [15:0] pitch;
		logic zero_field;
	} sample_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	logic [3:0] mount_sel;
	logic [15:0] gain_x, gain_y, gain_z;
	heading_t pending_headings[$];
	int errors;
	int cycles;
	int sent;
	int idle_mode;
	bit hold_rx;

	sample_row_t sample_table [0:15] = '{
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 1'b1},
		'{16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
		'{-16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
		'{16'sd1000, 16'sd500, 16'sd0, 16'sd0, 16'sd0, 1'b0},
		'{16'sd1000, -16'sd500, 16'sd0, 16'sd0, 16'sd0, 1'b0},
		'{16'sd0, 16'sd1200, 16'sd0, 16'sd0, 16'sd0, 1'b0},
		'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 1'b0},
		'{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 1'b0},
		'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0},
		'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 1'b0},
		'{16'sd300, -16'sd700, 16'sd900, 16'sd20000, -16'sd20000, 1'b0},
		'{16'sd300, -16'sd700, 16'sd900, 16'sd12868, 16'sd12869, 1'b0},
		'{-16'sd4000, 16'sd2500, -16'sd900, -16'sd12868, -16'sd12869, 1'b0},
		'{-16'sd1, 16'sd1, 16'sd1, 16'sd1, -16'sd1, 1'b0},
		'{16'sd0, 16'sd0, 16'sd5000, 16'sd4000, 16'sd3000, 1'b0}
	};

	tilt_compensated_compass_heading_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint round_shift(input longint v, input int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint arctan_step(input int i);
		return round_shift(ATAN_Q32[i], 32 - ANGLE_BITS);
	endfunction

	task automatic rotate_unit(input longint ang, output longint c, output longint s);
		longint x, y, z, xs, ys, pi_a, half_a;
		bit flip;
		pi_a = round_shift(PI_Q32, 32 - ANGLE_BITS);
		half_a = round_shift(PI_Q32, 33 - ANGLE_BITS);
		x = K_Q30;
		y = 0;
		z = ang;
		flip = 1'b0;
		if (z > half_a) begin
			z -= pi_a;
			flip = 1'b1;
		end else if (z < -half_a) begin
			z += pi_a;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= arctan_step(i);
			end else begin
				x += ys;
				y -= xs;
				z += arctan_step(i);
			end
		end
		x = round_shift(x, 16);
		y = round_shift(y, 16);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint vector_angle(input longint y_in, input longint x_in);
		longint x, y, z, xs, ys;
		if (x_in == 0 && y_in == 0) return 0;
		x = x_in <<< 20;
		y = y_in <<< 20;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? round_shift(PI_Q32, 32 - ANGLE_BITS)
				: -round_shift(PI_Q32, 32 - ANGLE_BITS);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x -= ys;
				y += xs;
				z -= arctan_step(i);
			end else begin
				x += ys;
				y -= xs;
				z += arctan_step(i);
			end
		end
		return z;
	endfunction

	task automatic predict_heading(input logic [IN_W-1:0] d, output heading_t res);
		longint v[3], r[3];
		longint cr, sr, cp, sp, hx, hy, ang, hc, hs;
		v[0] = round_shift(-longint'($signed(d[15:0])) * longint'(gain_x), 14);
		v[1] = round_shift(longint'($signed(d[31:16])) * longint'(gain_y), 14);
		v[2] = round_shift(-longint'($signed(d[47:32])) * longint'(gain_z), 14);
		for (int k = 0; k < 3; k++)
			r[k] = round_shift(longint'(MOUNT_MAT[mount_sel][3*k]) * v[0]
				+ longint'(MOUNT_MAT[mount_sel][3*k+1]) * v[1]
				+ longint'(MOUNT_MAT[mount_sel][3*k+2]) * v[2], 14);
		rotate_unit(round_shift(longint'($signed(d[63:48])) <<< ANGLE_BITS, 13), cr, sr);
		rotate_unit(round_shift(longint'($signed(d[79:64])) <<< ANGLE_BITS, 13), cp, sp);
		hx = round_shift(r[0] * cp * 16384 + r[1] * sr * sp + r[2] * cr * sp, 28);
		hy = round_shift(r[1] * cr - r[2] * sr, 14);
		ang = vector_angle(-hy, hx);
		rotate_unit(ang, hc, hs);
		res.heading = 16'(clamp(round_shift(ang * 8192, ANGLE_BITS), -25736, 25736));
		res.hcos = 16'(clamp(hc, -16384, 16384));
		res.hsin = 16'(clamp(hs, -16384, 16384));
		res.lvl_x = 20'(clamp(hx, -524288, 524287));
		res.lvl_y = 20'(clamp(hy, -524288, 524287));
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			case (idle_mode)
				0: m_tready <= !hold_rx && ($urandom_range(99) >= 51);
				1: m_tready <= !hold_rx && ($urandom_range(99) >= 12);
				default: m_tready <= !hold_rx;
			endcase
		end
	end

	always @(posedge clk) begin
		heading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_headings.size() == 0) begin
				report("item count", longint'(pending_headings.size()) + 1, 0);
			end else begin
				want = pending_headings.pop_front();
				if ($signed(m_tdata[15:0]) != want.heading)
					report("heading", $signed(m_tdata[15:0]), want.heading);
				if ($signed(m_tdata[31:16]) != want.hcos)
					report("heading_cos", $signed(m_tdata[31:16]), want.hcos);
				if ($signed(m_tdata[47:32]) != want.hsin)
					report("heading_sin", $signed(m_tdata[47:32]), want.hsin);
				if ($signed(m_tdata[67:48]) != want.lvl_x)
					report("level_x", $signed(m_tdata[67:48]), want.lvl_x);
				if ($signed(m_tdata[87:68]) != want.lvl_y)
					report("level_y", $signed(m_tdata[87:68]), want.lvl_y);
			end
		end
	end

	// Once the sender has moved some items, the receiver stops long enough to fill the block.
	initial begin
		hold_rx = 1'b0;
		wait (sent >= 300);
		@(posedge clk);
		hold_rx = 1'b1;
		repeat (200) @(posedge clk);
		hold_rx = 1'b0;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MOUNT: mount_sel = val[3:0];
			REG_GAIN_X: gain_x = val;
			REG_GAIN_Y: gain_y = val;
			REG_GAIN_Z: gain_z = val;
			default: ;
		endcase
	endtask

	task automatic send_sample(input logic [IN_W-1:0] d, input bit zero_field);
		heading_t want;
		int gap_pct;
		s_tvalid <= 1'b1;
		s_tdata <= d;
		if (zero_field) begin
			want.heading = 0;
			want.hcos = 16384;
			want.hsin = 0;
			want.lvl_x = 0;
			want.lvl_y = 0;
		end else begin
			predict_heading(d, want);
		end
		do @(posedge clk); while (!s_tready);
		pending_headings.push_back(want);
		sent++;
		idle_mode = sent < 600 ? 0 : (sent < 1200 ? 1 : 2);
		gap_pct = idle_mode == 0 ? 12 : (idle_mode == 1 ? 51 : 0);
		if ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] rand_field();
		case ($urandom_range(3))
			0: return 16'($urandom_range(4000)) - 16'd2000;
			1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending_headings.size() == 0);
		@(posedge clk);
	endtask

	initial begin
		logic [IN_W-1:0] d;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		errors = 0;
		cycles = 0;
		sent = 0;
		idle_mode = 0;
		mount_sel = 4'd0;
		gain_x = GAIN_RESET;
		gain_y = GAIN_RESET;
		gain_z = GAIN_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (sample_table[i])
			send_sample({sample_table[i].pitch, sample_table[i].roll, sample_table[i].rz,
				sample_table[i].ry, sample_table[i].rx}, sample_table[i].zero_field);
		drain();

		for (int ph = 0; ph < 17; ph++) begin
			write_reg(REG_MOUNT, 16'(ph % 16));
			case (ph)
				1: begin
					write_reg(REG_GAIN_X, 16'd0);
					write_reg(REG_GAIN_Y, 16'd0);
					write_reg(REG_GAIN_Z, 16'd0);
				end
				2: begin
					write_reg(REG_GAIN_X, 16'hFFFF);
					write_reg(REG_GAIN_Y, 16'hFFFF);
					write_reg(REG_GAIN_Z, 16'hFFFF);
					write_reg(REG_UNUSED, 16'h1234);
				end
				default: begin
					write_reg(REG_GAIN_X, 16'($urandom_range(65535)));
					write_reg(REG_GAIN_Y, 16'($urandom_range(32768, 8192)));
					write_reg(REG_GAIN_Z, 16'($urandom_range(65535)));
				end
			endcase
			cfg_valid <= 1'b0;
			for (int n = 0; n < 102; n++) begin
				d = {rand_field(), rand_field(), rand_field(), rand_field(), rand_field()};
				send_sample(d, 1'b0);
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/thcc_pkg.sv
src/thcc_sincos.sv
src/tilt_compensated_compass_heading_core.sv
src/thcc_checker.sv
tb/tilt_compensated_compass_heading_core_tb.sv
